>>> hdl/rrtp_pkg.sv
// Shared types and constants for the round-robin thread picker.
// No dependencies; used by rrtp_table, round_robin_thread_picker_unit, thread_pick_checker and testbench.
package rrtp_pkg;

    // Table capacity that the fixed-width fields can address.
    localparam int TCAP            = 8;
    localparam int MAX_THREADS_DEF = 8;
    localparam int CNT_W           = 4;

    // Transaction kinds
    localparam logic [2:0] K_SET   = 3'd0;
    localparam logic [2:0] K_SEL   = 3'd1;
    localparam logic [2:0] K_MERGE = 3'd2;
    localparam logic [2:0] K_PTR   = 3'd3;
    localparam logic [2:0] K_QUERY = 3'd4;

    // Thread status codes
    localparam logic [1:0] ST_DIS = 2'd0;
    localparam logic [1:0] ST_EN  = 2'd1;
    localparam logic [1:0] ST_SLP = 2'd2;
    localparam logic [1:0] ST_RSV = 2'd3;

    // Configuration register indexes
    localparam logic CFG_FAIR  = 1'b0;
    localparam logic CFG_YIELD = 1'b1;

    typedef struct packed {
        logic [2:0]  kind;
        logic [2:0]  thread_id;
        logic [1:0]  new_status;
        logic [7:0]  priority_mask;
        logic [63:0] priority_over;
        logic [7:0]  sleep_mask;
    } t_in_item;

    typedef struct packed {
        logic             selected_valid;
        logic [2:0]       selected_thread;
        logic             thread_active;
        logic             thread_asleep;
        logic             all_sleeping;
        logic             disabled_event;
        logic [CNT_W-1:0] known_threads;
    } t_out_item;

    // Update command from the sequencer to the status table
    typedef struct packed {
        logic       set_en;
        logic       merge_en;
        logic [2:0] tid;
        logic [1:0] nst;
        logic [7:0] smask;
    } t_tbl_cmd;

    // Status seen by the sequencer; only counted threads show up in the masks
    typedef struct packed {
        logic [TCAP-1:0]  en_mask;
        logic [TCAP-1:0]  sl_mask;
        logic [CNT_W-1:0] total;
    } t_tbl_stat;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_EXEC = 5'b00010,
        S_MOD  = 5'b00100,
        S_WALK = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

endpackage

>>> hdl/rrtp_table.sv
// Per-thread status table and known-thread count.
// Depends on rrtp_pkg for the command and status structs.
module rrtp_table #(
    parameter int MAX_THREADS = rrtp_pkg::MAX_THREADS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rrtp_pkg::t_tbl_cmd  i_cmd,
    output rrtp_pkg::t_tbl_stat o_stat
);
    import rrtp_pkg::*;

    localparam int TW = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;

    logic [1:0]       r_st [MAX_THREADS];
    logic [CNT_W-1:0] r_total;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_THREADS; i++) begin
                r_st[i] <= ST_DIS;
            end
            r_total <= '0;
        end else begin
            if (i_cmd.set_en) begin
                // grow the count, filling the new entries as disabled
                if (CNT_W'(i_cmd.tid) >= r_total) begin
                    for (int i = 0; i < MAX_THREADS; i++) begin
                        if (CNT_W'(i) >= r_total && CNT_W'(i) < CNT_W'(i_cmd.tid)) begin
                            r_st[i] <= ST_DIS;
                        end
                    end
                    r_total <= CNT_W'(i_cmd.tid) + CNT_W'(1);
                end
                r_st[i_cmd.tid[TW-1:0]] <= i_cmd.nst;
            end
            if (i_cmd.merge_en) begin
                for (int i = 0; i < MAX_THREADS; i++) begin
                    if (CNT_W'(i) < r_total && i_cmd.smask[i]) begin
                        r_st[i] <= ST_SLP;
                    end
                end
            end
        end
    end

    always_comb begin
        o_stat.en_mask = '0;
        o_stat.sl_mask = '0;
        o_stat.total   = r_total;
        for (int i = 0; i < MAX_THREADS; i++) begin
            if (CNT_W'(i) < r_total) begin
                o_stat.en_mask[i] = (r_st[i] == ST_EN);
                o_stat.sl_mask[i] = (r_st[i] == ST_SLP);
            end
        end
    end

endmodule

>>> hdl/round_robin_thread_picker_unit.sv
// Round-robin thread picker: sequencer, candidate check and result register.
// Depends on rrtp_pkg and rrtp_table.
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+------------------------
//  input   | in        | i_in_valid / o_in_ready  | i_in_data  (t_in_item)
//  output  | out       | o_out_valid / i_out_ready| o_out_data (t_out_item)
//  config  | in        | i_cfg_we (no wait)       | i_cfg_idx, i_cfg_data
//
// Set status, merge, set pointer, query and unknown kinds pass S_EXEC and S_DONE.
// Select with a non-zero count adds S_MOD, where 0..8 subtract steps reduce pointer+1
// modulo the count, and S_WALK, where 1..MAX_THREADS candidates are checked one a
// cycle. One transaction is in flight; a stalled result holds the sequencer in its
// final state. Reset is synchronous and clears table and pointer.
module round_robin_thread_picker_unit #(
    parameter int MAX_THREADS = rrtp_pkg::MAX_THREADS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  rrtp_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output rrtp_pkg::t_out_item o_out_data,
    input  logic                i_cfg_we,
    input  logic                i_cfg_idx,
    input  logic                i_cfg_data
);
    import rrtp_pkg::*;

    t_state           r_state, n_state;
    t_in_item         r_item;
    logic             r_fair_on, r_yield_on;
    logic [2:0]       r_ptr, n_ptr;
    logic [CNT_W-1:0] r_cand, n_cand;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_fair, n_fair;
    logic             r_sel_v, n_sel_v;
    logic [2:0]       r_sel_t, n_sel_t;
    logic             r_dis, n_dis;
    logic             r_out_v;
    t_out_item        r_out;

    t_tbl_cmd  tbl_cmd;
    t_tbl_stat tbl_stat;

    logic [TCAP-1:0]  live;
    logic [2:0]       cand;
    logic [7:0]       over_row;
    logic             skip, hit, set_ok, out_load;
    logic [CNT_W-1:0] cand_inc;

    rrtp_table #(.MAX_THREADS(MAX_THREADS)) u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (tbl_cmd),
        .o_stat  (tbl_stat)
    );

    assign live     = tbl_stat.en_mask | tbl_stat.sl_mask;
    assign cand     = r_cand[2:0];
    assign over_row = r_item.priority_over[{cand, 3'b000} +: 8];
    assign skip     = r_yield_on && |(over_row & live);
    assign hit      = !skip && tbl_stat.en_mask[cand]
                      && (!r_fair || r_item.priority_mask[cand]);
    assign cand_inc = r_cand + CNT_W'(1);
    assign set_ok   = (CNT_W'(r_item.thread_id) < CNT_W'(MAX_THREADS))
                      && (r_item.new_status != ST_RSV);
    assign out_load = (r_state == S_DONE) && (!r_out_v || i_out_ready);

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;

    always_comb begin
        n_state = r_state;
        n_ptr   = r_ptr;
        n_cand  = r_cand;
        n_cnt   = r_cnt;
        n_fair  = r_fair;
        n_sel_v = r_sel_v;
        n_sel_t = r_sel_t;
        n_dis   = r_dis;
        tbl_cmd = '0;
        tbl_cmd.tid   = r_item.thread_id;
        tbl_cmd.nst   = r_item.new_status;
        tbl_cmd.smask = r_item.sleep_mask;
        case (r_state)
            S_IDLE: begin
                n_sel_v = 1'b0;
                n_sel_t = '0;
                n_dis   = 1'b0;
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_DONE;
                case (r_item.kind)
                    K_SET: begin
                        tbl_cmd.set_en = set_ok;
                        n_dis = set_ok && (r_item.new_status == ST_DIS);
                    end
                    K_MERGE: tbl_cmd.merge_en = 1'b1;
                    K_PTR:   n_ptr = r_item.thread_id;
                    K_SEL: begin
                        if (tbl_stat.total != '0) begin
                            n_fair  = r_fair_on && |(r_item.priority_mask & live);
                            n_cand  = CNT_W'(r_ptr) + CNT_W'(1);
                            n_cnt   = '0;
                            n_state = S_MOD;
                        end
                    end
                    default: ;
                endcase
            end
            S_MOD: begin
                // reduce the start position modulo the count, one subtract a cycle
                if (r_cand >= tbl_stat.total) begin
                    n_cand = r_cand - tbl_stat.total;
                end else begin
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                n_ptr = cand;
                if (hit) begin
                    n_sel_v = 1'b1;
                    n_sel_t = cand;
                    n_state = S_DONE;
                end else if (r_cnt == tbl_stat.total - CNT_W'(1)) begin
                    n_state = S_DONE;
                end else begin
                    n_cnt  = r_cnt + CNT_W'(1);
                    n_cand = (cand_inc == tbl_stat.total) ? '0 : cand_inc;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_ptr      <= '0;
            r_out_v    <= 1'b0;
            r_fair_on  <= 1'b0;
            r_yield_on <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ptr   <= n_ptr;
            if (out_load) begin
                r_out_v <= 1'b1;
            end else if (i_out_ready) begin
                r_out_v <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_FAIR:  r_fair_on  <= i_cfg_data;
                    CFG_YIELD: r_yield_on <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in_valid) begin
            r_item <= i_in_data;
        end
        r_cand  <= n_cand;
        r_cnt   <= n_cnt;
        r_fair  <= n_fair;
        r_sel_v <= n_sel_v;
        r_sel_t <= n_sel_t;
        r_dis   <= n_dis;
        if (out_load) begin
            r_out.selected_valid  <= r_sel_v;
            r_out.selected_thread <= r_sel_t;
            r_out.thread_active   <= live[r_item.thread_id];
            r_out.thread_asleep   <= tbl_stat.sl_mask[r_item.thread_id];
            r_out.all_sleeping    <= (tbl_stat.en_mask == '0) && (tbl_stat.sl_mask != '0);
            r_out.disabled_event  <= r_dis;
            r_out.known_threads   <= tbl_stat.total;
        end
    end

    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tbl_stat.total <= CNT_W'(MAX_THREADS))
        else $error("thread count exceeds table depth");

    a_walk_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (r_cand < tbl_stat.total) && (r_cnt < tbl_stat.total))
        else $error("walk candidate or step count out of range");

    a_sel_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.selected_valid)
            |-> (CNT_W'(o_out_data.selected_thread) < o_out_data.known_threads))
        else $error("selected thread is not a counted thread");

    a_sleep_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.all_sleeping && o_out_data.thread_active)
            |-> o_out_data.thread_asleep)
        else $error("all sleeping reported with an enabled thread");

    a_busy_no_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_in_ready && i_in_valid) |=> !o_in_ready ##1 !o_in_ready)
        else $error("accepted a transaction while one is in flight");

endmodule

>>> sim/thread_pick_checker.sv
`timescale 1ns / 1ps
// Checker for the round-robin thread picker: watches the input, output and config ports,
// predicts one result per input transaction and compares it field by field.
// Depends on rrtp_pkg.
module thread_pick_checker #(
    parameter int MAX_THREADS = rrtp_pkg::MAX_THREADS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  rrtp_pkg::t_in_item  i_in_data,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  rrtp_pkg::t_out_item i_out_data,
    input  logic                i_cfg_we,
    input  logic                i_cfg_idx,
    input  logic                i_cfg_data,
    output int                  o_errors,
    output int                  o_pending
);
    import rrtp_pkg::*;

    logic [1:0] status_tbl [8];
    int         thread_total;
    int         rr_ptr;
    logic       fair_en;
    logic       yield_en;
    t_out_item  pick_expect_q [$];
    int         mismatches = 0;
    int         queued     = 0;

    assign o_errors  = mismatches;
    assign o_pending = queued;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t ns: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
        mismatches++;
    endtask

    // Apply one transaction to the shadow table and return the result it should produce.
    function automatic t_out_item predict_pick(input t_in_item it);
        t_out_item  r;
        logic [2:0] tid;
        logic       fair_live;
        logic       found;
        logic       skip;
        logic       any_en;
        logic       any_slp;
        int         n;
        int         start;
        int         c;
        int         k;
        int         j;
        r   = '0;
        tid = it.thread_id;
        case (it.kind)
            K_SET: begin
                if (int'(tid) < MAX_THREADS && it.new_status != ST_RSV) begin
                    // grow the count, filling new entries as disabled
                    if (int'(tid) >= thread_total) begin
                        for (k = thread_total; k <= int'(tid); k++) status_tbl[k] = ST_DIS;
                        thread_total = int'(tid) + 1;
                    end
                    status_tbl[tid]  = it.new_status;
                    r.disabled_event = (it.new_status == ST_DIS);
                end
            end
            K_SEL: begin
                n = thread_total;
                if (n > 0) begin
                    fair_live = 1'b0;
                    if (fair_en) begin
                        for (k = 0; k < n; k++)
                            if (it.priority_mask[k] && status_tbl[k] != ST_DIS) fair_live = 1'b1;
                    end
                    start = rr_ptr;
                    found = 1'b0;
                    // pointer ends on the last candidate examined
                    for (k = 0; k < n && !found; k++) begin
                        c      = (start + k + 1) % n;
                        rr_ptr = c;
                        skip   = 1'b0;
                        if (yield_en) begin
                            for (j = 0; j < n; j++)
                                if (status_tbl[j] != ST_DIS && it.priority_over[c * 8 + j])
                                    skip = 1'b1;
                        end
                        if (!skip && status_tbl[c] == ST_EN &&
                            (!fair_live || it.priority_mask[c])) begin
                            found             = 1'b1;
                            r.selected_valid  = 1'b1;
                            r.selected_thread = c[2:0];
                        end
                    end
                end
            end
            K_MERGE: begin
                for (k = 0; k < thread_total; k++)
                    if (it.sleep_mask[k]) status_tbl[k] = ST_SLP;
            end
            K_PTR: rr_ptr = int'(tid);
            default: ;
        endcase

        r.thread_active = (int'(tid) < thread_total) && (status_tbl[tid] != ST_DIS);
        r.thread_asleep = (int'(tid) < thread_total) && (status_tbl[tid] == ST_SLP);
        any_en  = 1'b0;
        any_slp = 1'b0;
        for (k = 0; k < thread_total; k++) begin
            if (status_tbl[k] == ST_EN)  any_en  = 1'b1;
            if (status_tbl[k] == ST_SLP) any_slp = 1'b1;
        end
        r.all_sleeping  = !any_en && any_slp;
        r.known_threads = thread_total[CNT_W-1:0];
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_out_item want;
        int        k;
        if (!i_rst_n) begin
            for (k = 0; k < 8; k++) status_tbl[k] = ST_DIS;
            thread_total = 0;
            rr_ptr       = 0;
            fair_en      = 1'b0;
            yield_en     = 1'b0;
            pick_expect_q.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_FAIR) fair_en = i_cfg_data;
                else                       yield_en = i_cfg_data;
            end
            if (i_in_valid && i_in_ready) pick_expect_q.push_back(predict_pick(i_in_data));
            if (i_out_valid && i_out_ready) begin
                if (pick_expect_q.size() == 0) begin
                    report_mismatch("unexpected result", 64'(i_out_data), '0);
                end else begin
                    want = pick_expect_q.pop_front();
                    if (i_out_data.selected_valid != want.selected_valid)
                        report_mismatch("selected_valid", 64'(i_out_data.selected_valid),
                                        64'(want.selected_valid));
                    if (i_out_data.selected_thread != want.selected_thread)
                        report_mismatch("selected_thread", 64'(i_out_data.selected_thread),
                                        64'(want.selected_thread));
                    if (i_out_data.thread_active != want.thread_active)
                        report_mismatch("thread_active", 64'(i_out_data.thread_active),
                                        64'(want.thread_active));
                    if (i_out_data.thread_asleep != want.thread_asleep)
                        report_mismatch("thread_asleep", 64'(i_out_data.thread_asleep),
                                        64'(want.thread_asleep));
                    if (i_out_data.all_sleeping != want.all_sleeping)
                        report_mismatch("all_sleeping", 64'(i_out_data.all_sleeping),
                                        64'(want.all_sleeping));
                    if (i_out_data.disabled_event != want.disabled_event)
                        report_mismatch("disabled_event", 64'(i_out_data.disabled_event),
                                        64'(want.disabled_event));
                    if (i_out_data.known_threads != want.known_threads)
                        report_mismatch("known_threads", 64'(i_out_data.known_threads),
                                        64'(want.known_threads));
                end
            end
        end
        queued <= pick_expect_q.size();
    end

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps
// Top of the thread picker testbench: clock, reset, stimulus, config writes and verdict.
// Depends on rrtp_pkg, round_robin_thread_picker_unit and thread_pick_checker.
module testbench;
    import rrtp_pkg::*;

    localparam int NTHREADS    = MAX_THREADS_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 75;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    t_in_item  in_data   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_data;
    logic      cfg_we    = 1'b0;
    logic      cfg_idx   = CFG_FAIR;
    logic      cfg_data  = 1'b0;
    int        errors;
    int        pending;
    logic      quiet     = 1'b0;
    int        stall_left = 3;
    int unsigned cycles  = 0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    round_robin_thread_picker_unit #(.MAX_THREADS(NTHREADS)) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    thread_pick_checker #(.MAX_THREADS(NTHREADS)) u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in_data   (in_data),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

    // Result side: after each accepted result, ready may be held low for a random stall; quiet keeps it high.
    always @(posedge clk) begin : result_side
        int w;
        if (out_valid && out_ready) begin
            w = quiet ? 0 : $urandom_range(0, 14);
            out_ready  <= (w == 0);
            stall_left <= w;
        end else if (!out_ready) begin
            if (stall_left <= 1) out_ready <= 1'b1;
            stall_left <= stall_left - 1;
        end
    end

    function automatic t_in_item mk(input logic [2:0] kind, input logic [2:0] tid,
                                    input logic [1:0] nst, input logic [7:0] pmask,
                                    input logic [63:0] over, input logic [7:0] smask);
        t_in_item it;
        it.kind          = kind;
        it.thread_id     = tid;
        it.new_status    = nst;
        it.priority_mask = pmask;
        it.priority_over = over;
        it.sleep_mask    = smask;
        return it;
    endfunction

    function automatic t_in_item random_pick_item();
        t_in_item it;
        int       roll;
        roll = $urandom_range(0, 99);
        if      (roll < 34) it.kind = K_SET;
        else if (roll < 66) it.kind = K_SEL;
        else if (roll < 74) it.kind = K_MERGE;
        else if (roll < 84) it.kind = K_PTR;
        else if (roll < 92) it.kind = K_QUERY;
        else                it.kind = 3'($urandom_range(5, 7));
        it.thread_id = 3'($urandom_range(0, 7));
        // favor enabled so that selects find something
        roll = $urandom_range(0, 9);
        if      (roll < 5) it.new_status = ST_EN;
        else if (roll < 7) it.new_status = ST_DIS;
        else if (roll < 9) it.new_status = ST_SLP;
        else               it.new_status = ST_RSV;
        it.priority_mask = 8'($urandom);
        case ($urandom_range(0, 3))
            0:       it.priority_over = '0;
            1:       it.priority_over = {$urandom, $urandom};
            default: it.priority_over = {$urandom, $urandom} & {$urandom, $urandom} &
                                        {$urandom, $urandom} & {$urandom, $urandom};
        endcase
        if ($urandom_range(0, 3) == 0) it.sleep_mask = 8'($urandom);
        else                           it.sleep_mask = 8'b1 << $urandom_range(0, 7);
        return it;
    endfunction

    task automatic send_item(input t_in_item it);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge clk); while (!in_ready);
    endtask

    // Drop valid and wait until every expected result has come back.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_regs(input logic fair, input logic yld);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_FAIR;
        cfg_data <= fair;
        @(posedge clk);
        cfg_idx  <= CFG_YIELD;
        cfg_data <= yld;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    initial begin
        int   p;
        int   i;
        logic f;
        logic y;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        set_regs(1'b0, 1'b0);
        quiet = 1'b0;
        send_item(mk(K_QUERY, 3'd0, ST_EN, 8'hFF, '1, 8'hFF));
        send_item(mk(K_SEL,   3'd0, ST_EN, 8'hFF, '0, 8'h00));
        send_item(mk(K_PTR,   3'd7, ST_EN, 8'h00, '0, 8'h00));
        send_item(mk(K_SET,   3'd2, ST_EN, 8'h00, '0, 8'h00));
        send_item(mk(K_SEL,   3'd2, ST_EN, 8'h00, '1, 8'h00));
        send_item(mk(K_SET,   3'd0, ST_RSV, 8'h00, '0, 8'h00));
        send_item(mk(K_SET,   3'd7, ST_DIS, 8'h00, '0, 8'h00));
        send_item(mk(K_SET,   3'd5, ST_EN, 8'h00, '0, 8'h00));
        send_item(mk(K_SET,   3'd0, ST_EN, 8'h00, '0, 8'h00));
        // sleep bit on a disabled counted thread still puts it to sleep
        send_item(mk(K_MERGE, 3'd7, ST_EN, 8'h00, '0, 8'hA1));
        send_item(mk(K_QUERY, 3'd7, ST_EN, 8'h00, '0, 8'h00));
        send_item(mk(K_SET,   3'd2, ST_SLP, 8'h00, '0, 8'h00));
        send_item(mk(K_SEL,   3'd2, ST_EN, 8'hFF, '0, 8'h00));
        send_item(mk(3'd5,    3'd3, ST_EN, 8'h00, '0, 8'h00));
        send_item(mk(3'd7,    3'd5, ST_DIS, 8'h00, '0, 8'hFF));
        send_item(mk(K_MERGE, 3'd1, ST_EN, 8'h00, '0, 8'hFF));
        send_item(mk(K_SET,   3'd1, ST_EN, 8'h00, '0, 8'h00));
        send_item(mk(K_SET,   3'd3, ST_EN, 8'h00, '0, 8'h00));
        send_item(mk(K_SET,   3'd4, ST_EN, 8'h00, '0, 8'h00));
        drain();

        set_regs(1'b1, 1'b1);
        quiet = 1'b1;
        send_item(mk(K_SEL, 3'd4, ST_EN, 8'h10, '0, 8'h00));
        send_item(mk(K_SEL, 3'd0, ST_EN, 8'h00, '1, 8'h00));
        send_item(mk(K_SEL, 3'd3, ST_EN, 8'hFF, 64'h1 << (3 * 8 + 3), 8'h00));
        send_item(mk(K_SEL, 3'd7, ST_EN, 8'h80, '0, 8'h00));
        send_item(mk(K_PTR, 3'd0, ST_EN, 8'hFF, '1, 8'hFF));
        send_item(mk(K_SEL, 3'd1, ST_EN, 8'h00, '0, 8'h00));
        drain();

        for (p = 0; p < 6; p++) begin
            if (p < 4) begin
                f = p[0];
                y = p[1];
            end else begin
                f = 1'($urandom);
                y = 1'($urandom);
            end
            set_regs(f, y);
            for (i = 0; i < PHASE_ITEMS; i++) begin
                if (i % 25 == 0) quiet = ($urandom_range(0, 3) == 0);
                send_item(random_pick_item());
            end
            drain();
        end

        repeat (20) @(posedge clk);
        if (errors == 0 && pending == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule

>>> files.f
hdl/rrtp_pkg.sv
hdl/rrtp_table.sv
hdl/round_robin_thread_picker_unit.sv
sim/thread_pick_checker.sv
sim/testbench.sv
